>>> rtl/htat_pkg.sv
// Shared types, constants and helpers for the host traffic accounting table.
package htat_pkg;

   localparam int LocalSlotsDef  = 64;
   localparam int RemoteSlotsDef = 16;

   localparam logic [31:0] HomePrefixRst = 32'hC0A8_0000;
   localparam logic [31:0] HomeMaskRst   = 32'hFFFF_0000;

   localparam logic [1:0] MODE_COUNT  = 2'd0;
   localparam logic [1:0] MODE_RD_LOC = 2'd1;
   localparam logic [1:0] MODE_RD_REM = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] ST_UP          = 3'd0;
   localparam logic [2:0] ST_DOWN        = 3'd1;
   localparam logic [2:0] ST_NOT_HOME    = 3'd2;
   localparam logic [2:0] ST_LOCAL_FULL  = 3'd3;
   localparam logic [2:0] ST_REMOTE_FULL = 3'd4;
   localparam logic [2:0] ST_READ_OK     = 3'd5;
   localparam logic [2:0] ST_EMPTY       = 3'd6;
   localparam logic [2:0] ST_CLEARED     = 3'd7;

   localparam logic CSR_PREFIX = 1'b0;
   localparam logic CSR_MASK   = 1'b1;

   localparam int ReqBits = 96;
   localparam int RspBits = 112;

   // Classified command handed from front to back.
   typedef struct packed {
      logic [1:0]  mode;
      logic        up;
      logic [31:0] loc;
      logic [31:0] rem;
      logic [15:0] len;
      logic [9:0]  lslot;
      logic [7:0]  rslot;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [4:0]  sessions;
      logic [31:0] upload;
      logic [31:0] download;
      logic [6:0]  used;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

>>> rtl/htat_front.sv
// Front end: accepts request words, classifies packets against the home prefix.
module htat_front import htat_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ReqBits-1:0] req_tdata,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);
   logic [31:0] prefix_ff, mask_ff;
   logic        valid_ff;
   cmd_type     cmd_ff, cmd_in;
   logic [1:0]  mode;
   logic [31:0] src, dst, home;
   logic        src_home, dst_home;

   assign mode = req_tdata[1:0];
   assign src  = req_tdata[33:2];
   assign dst  = req_tdata[65:34];
   assign home = prefix_ff & mask_ff;
   assign src_home = (src & mask_ff) == home;
   assign dst_home = (dst & mask_ff) == home;

   always_comb begin
      cmd_in       = '0;
      cmd_in.mode  = mode;
      cmd_in.up    = src_home;
      cmd_in.loc   = src_home ? src : dst;
      cmd_in.rem   = src_home ? dst : src;
      cmd_in.len   = req_tdata[81:66];
      cmd_in.lslot = {4'd0, req_tdata[87:82]};
      cmd_in.rslot = {4'd0, req_tdata[91:88]};
      // not-home packets become their own marker: mode count, loc unused
      if (mode == MODE_COUNT && !src_home && !dst_home) begin
         cmd_in.lslot = '1;
         cmd_in.rslot = '1;
         cmd_in.up    = 1'b0;
         cmd_in.loc   = '0;
         cmd_in.rem   = '0;
         cmd_in.len   = '0;
         cmd_in.mode  = MODE_COUNT;
      end
   end

   // not-home flag rides in an otherwise unused bit pattern; keep it explicit
   logic nothome_ff;
   logic nothome_in;
   assign nothome_in = (mode == MODE_COUNT) && !src_home && !dst_home;

   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   always_comb begin
      cmd = cmd_ff;
      if (nothome_ff) cmd.mode = MODE_COUNT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= HomePrefixRst;
         mask_ff   <= HomeMaskRst;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_PREFIX) prefix_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_MASK)   mask_ff   <= csr_wdata;
         if (req_tready) valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         cmd_ff     <= cmd_in;
         nothome_ff <= nothome_in;
      end
   end
endmodule

>>> rtl/htat_queue.sv
// Short command queue decoupling the front end from the table engine.
module htat_queue import htat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   input  logic    in_nothome,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd,
   output logic    out_nothome
);
   cmd_type     q_ff [2];
   logic        nh_ff [2];
   logic [1:0]  cnt_ff;
   logic        wp_ff, rp_ff;
   logic        push, pop;

   assign in_ready    = cnt_ff != 2'd2;
   assign out_valid   = cnt_ff != 2'd0;
   assign push        = in_valid && in_ready;
   assign pop         = out_valid && out_ready;
   assign out_cmd     = q_ff[rp_ff];
   assign out_nothome = nh_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         q_ff[wp_ff]  <= in_cmd;
         nh_ff[wp_ff] <= in_nothome;
      end
   end
endmodule

>>> rtl/htat_engine.sv
// Table engine: sequential search, update and read of local and remote tables.
module htat_engine import htat_pkg::*; #(
   parameter int LOCAL_SLOTS  = LocalSlotsDef,
   parameter int REMOTE_SLOTS = RemoteSlotsDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   input  logic    cmd_nothome,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);
   localparam int LW = $clog2(LOCAL_SLOTS);
   localparam int RW = $clog2(REMOTE_SLOTS);
   localparam int CW = $clog2(LOCAL_SLOTS + 1);
   localparam int SW = $clog2(REMOTE_SLOTS + 1);
   localparam int RD = LOCAL_SLOTS * (2 ** RW);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LRD   = 4'd1;  // local read issued
   localparam logic [3:0] S_LCMP  = 4'd2;
   localparam logic [3:0] S_LUPD  = 4'd3;
   localparam logic [3:0] S_RRD   = 4'd4;
   localparam logic [3:0] S_RCMP  = 4'd5;
   localparam logic [3:0] S_RUPD  = 4'd6;
   localparam logic [3:0] S_RDL   = 4'd7;
   localparam logic [3:0] S_RDR   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_RDR2  = 4'd10;

   // local memory word: addr, sessions, up, down
   typedef struct packed {
      logic [31:0]   addr;
      logic [SW-1:0] sess;
      logic [31:0]   up;
      logic [31:0]   down;
   } lent_type;
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] up;
      logic [31:0] down;
   } rent_type;

   lent_type lmem [LOCAL_SLOTS];
   rent_type rmem [RD];
   lent_type lrd_ff;
   rent_type rrd_ff;

   logic [3:0]       state_ff, state_in;
   cmd_type          c_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    li_ff;     // local scan index
   logic [SW-1:0]    rj_ff;     // remote scan index
   lent_type         lcur_ff;
   logic             rnew_ff, rfull_ff;
   rsp_type          out_ff;
   logic             out_v_ff;

   logic             l_we, r_we;
   logic [LW-1:0]    l_wa, l_ra;
   logic [LW+RW-1:0] r_wa, r_ra;
   lent_type         l_wd;
   rent_type         r_wd;

   logic [LW+RW-1:0] rbase;
   assign rbase = {li_ff[LW-1:0], {RW{1'b0}}};

   assign cmd_ready = state_ff == S_IDLE && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

   function automatic logic [4:0] sess5(input logic [SW-1:0] s);
      logic [SW+4:0] w;
      w = {5'd0, s};
      return w[4:0];
   endfunction
   function automatic logic [6:0] used7(input logic [CW-1:0] u);
      logic [CW+6:0] w;
      w = {7'd0, u};
      return w[6:0];
   endfunction

   always_ff @(posedge clock) begin
      if (l_we) lmem[l_wa] <= l_wd;
      lrd_ff <= lmem[l_ra];
      if (r_we) rmem[r_wa] <= r_wd;
      rrd_ff <= rmem[r_ra];
   end

   always_comb begin
      l_ra = li_ff[LW-1:0];
      r_ra = rbase + {{LW{1'b0}}, rj_ff[RW-1:0]};
      if (state_ff == S_IDLE) begin
         l_ra = cmd.lslot[LW-1:0];
         r_ra = {cmd.lslot[LW-1:0], cmd.rslot[RW-1:0]};
      end
      // read words hold the requested slots until the result is captured in S_RDR2
      if (state_ff == S_RDL || state_ff == S_RDR || state_ff == S_RDR2) begin
         l_ra = c_ff.lslot[LW-1:0];
         r_ra = {c_ff.lslot[LW-1:0], c_ff.rslot[RW-1:0]};
      end
   end

   logic       lhit, rhit;
   logic [SW-1:0] lsess;
   logic       loc_ok, rem_ok;
   assign lhit  = lrd_ff.addr == c_ff.loc;
   assign rhit  = rrd_ff.addr == c_ff.rem;
   assign lsess = lcur_ff.sess;
   assign loc_ok = int'(c_ff.lslot) < int'(count_ff);
   assign rem_ok = int'(c_ff.rslot) < int'(lrd_ff.sess);

   always_comb begin
      state_in = state_ff;
      l_we = 1'b0; l_wa = li_ff[LW-1:0]; l_wd = lcur_ff;
      r_we = 1'b0; r_wa = r_ra;          r_wd = '0;
      case (state_ff)
         S_IDLE: if (cmd_valid && cmd_ready) begin
            case (cmd.mode)
               MODE_COUNT: state_in = cmd_nothome ? S_OUT :
                                      (count_ff == '0 ? S_LCMP : S_LRD);
               MODE_RD_LOC, MODE_RD_REM: state_in = S_RDL;
               default: state_in = S_OUT;
            endcase
         end
         S_LRD:  state_in = S_LCMP;
         S_LCMP: begin
            if (li_ff < count_ff && lhit) state_in = S_LUPD;
            else if (li_ff + 1'b1 < count_ff) state_in = S_LRD;
            else state_in = S_LUPD;
         end
         S_LUPD: begin
            if (rfull_ff) state_in = S_OUT;
            else if (lsess == '0) state_in = S_RUPD;   // empty list: append at 0
            else state_in = S_RRD;
         end
         S_RRD:  state_in = S_RCMP;
         S_RCMP: begin
            if (rj_ff < lsess && rhit) state_in = S_RUPD;
            else if (rj_ff + 1'b1 < lsess) state_in = S_RRD;
            else state_in = S_RUPD;
         end
         S_RUPD: begin
            if (rnew_ff) begin
               r_we = 1'b1;
               r_wa = rbase + {{LW{1'b0}}, rj_ff[RW-1:0]};
               r_wd.addr = c_ff.rem;
               r_wd.up   = c_ff.up ? {16'd0, c_ff.len} : '0;
               r_wd.down = c_ff.up ? '0 : {16'd0, c_ff.len};
            end else if (!rfull_ff) begin
               r_we = 1'b1;
               r_wa = rbase + {{LW{1'b0}}, rj_ff[RW-1:0]};
               r_wd = rrd_ff;
               if (c_ff.up) r_wd.up = sat_add(rrd_ff.up, c_ff.len);
               else         r_wd.down = sat_add(rrd_ff.down, c_ff.len);
            end
            l_we = 1'b1;
            l_wd.sess = rnew_ff ? lsess + 1'b1 : lsess;
            state_in = S_OUT;
         end
         S_RDL:  state_in = S_RDR;
         S_RDR:  state_in = S_RDR2;
         S_RDR2: state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && rsp_ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd_valid && cmd_ready) begin
               c_ff     <= cmd;
               li_ff    <= '0;
               rj_ff    <= '0;
               rnew_ff  <= 1'b0;
               rfull_ff <= 1'b0;
               if (cmd.mode == MODE_COUNT && cmd_nothome) begin
                  out_ff <= '{status: ST_NOT_HOME, default: '0};
               end else if (cmd.mode == MODE_CLEAR) begin
                  out_ff   <= '{status: ST_CLEARED, default: '0};
                  count_ff <= '0;
               end else begin
                  out_ff <= '0;
               end
            end
            S_LCMP: begin
               if (li_ff < count_ff && lhit) begin
                  lcur_ff <= lrd_ff;
               end else if (li_ff + 1'b1 < count_ff) begin
                  li_ff <= li_ff + 1'b1;
               end else if (count_ff >= CW'(LOCAL_SLOTS)) begin
                  rfull_ff <= 1'b1;       // marks local full on the way out
                  c_ff.mode <= MODE_CLEAR;
               end else begin
                  li_ff <= count_ff;
                  lcur_ff <= '{addr: c_ff.loc, sess: '0, up: '0, down: '0};
                  count_ff <= count_ff + 1'b1;
               end
            end
            S_LUPD: begin
               if (c_ff.mode == MODE_CLEAR) begin
                  out_ff.status <= ST_LOCAL_FULL;
               end else begin
                  if (c_ff.up) lcur_ff.up <= sat_add(lcur_ff.up, c_ff.len);
                  else         lcur_ff.down <= sat_add(lcur_ff.down, c_ff.len);
                  if (lsess == '0) rnew_ff <= 1'b1;
               end
            end
            S_RCMP: begin
               if (rj_ff < lsess && rhit) begin
                  // hit: update in place
               end else if (rj_ff + 1'b1 < lsess) begin
                  rj_ff <= rj_ff + 1'b1;
               end else if (lsess >= SW'(REMOTE_SLOTS)) begin
                  rfull_ff <= 1'b1;
               end else begin
                  rj_ff   <= lsess;
                  rnew_ff <= 1'b1;
               end
            end
            S_RUPD: begin
               out_ff.status   <= rfull_ff ? ST_REMOTE_FULL : (c_ff.up ? ST_UP : ST_DOWN);
               out_ff.addr     <= lcur_ff.addr;
               out_ff.sessions <= sess5(rnew_ff ? lsess + 1'b1 : lsess);
               out_ff.upload   <= lcur_ff.up;
               out_ff.download <= lcur_ff.down;
               if (rnew_ff) lcur_ff.sess <= lsess + 1'b1;
            end
            S_RDR2: begin
               if (c_ff.mode == MODE_RD_LOC && loc_ok) begin
                  out_ff <= '{status: ST_READ_OK, addr: lrd_ff.addr,
                              sessions: sess5(lrd_ff.sess), upload: lrd_ff.up,
                              download: lrd_ff.down, used: '0};
               end else if (c_ff.mode == MODE_RD_REM && loc_ok && rem_ok) begin
                  out_ff <= '{status: ST_READ_OK, addr: rrd_ff.addr, sessions: '0,
                              upload: rrd_ff.up, download: rrd_ff.down, used: '0};
               end else begin
                  out_ff.status <= ST_EMPTY;
               end
            end
            S_OUT: begin
               out_v_ff     <= 1'b1;
               out_ff.used  <= used7(count_ff);
            end
            default: ;
         endcase
      end
   end
endmodule

>>> rtl/host_traffic_accounting_table_core.sv
// Top level of the host traffic accounting table.
// Counts packet bytes per local host and per remote host within each local host.
// A packet word is classified by the front end against home_prefix/home_mask and
// queued; the table engine scans the local table one entry at a time, a read
// state and then a compare state per entry, then that host's remote list
// likewise, and writes both updates back. Read words pass through S_RDL, S_RDR
// and S_RDR2; clear goes straight to the output state. The one-at-a-time scan
// follows from the single read port of each table memory. Clear simply zeroes
// the local fill count, so no clearing sweep is needed. One response word per
// request word, in order. The engine takes its next command only once the held
// response word has been taken; meanwhile the front register and the queue
// accept up to three more request words.
module host_traffic_accounting_table_core import htat_pkg::*; #(
   parameter int LOCAL_SLOTS  = LocalSlotsDef,
   parameter int REMOTE_SLOTS = RemoteSlotsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // mode[1:0], src_addr[33:2], dst_addr[65:34], pkt_length[81:66],
   // local_slot[87:82], remote_slot[91:88], zero fill
   input  logic [ReqBits-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // status[2:0], entry_addr[34:3], entry_sessions[39:35], entry_upload[71:40],
   // entry_download[103:72], local_used[110:104], zero fill
   output logic [RspBits-1:0] rsp_tdata,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   logic    f_valid, f_ready, q_valid, q_ready, q_nh;
   cmd_type f_cmd, q_cmd;
   rsp_type r;

   htat_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .csr_we, .csr_index, .csr_wdata,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   htat_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .in_nothome(f_cmd.lslot == '1 && f_cmd.rslot == '1 && f_cmd.loc == '0 &&
                  f_cmd.rem == '0 && f_cmd.mode == MODE_COUNT && !f_cmd.up),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd), .out_nothome(q_nh)
   );

   htat_engine #(.LOCAL_SLOTS(LOCAL_SLOTS), .REMOTE_SLOTS(REMOTE_SLOTS)) u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd), .cmd_nothome(q_nh),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(r)
   );

   assign rsp_tdata = {1'b0, r.used, r.download, r.upload, r.sessions, r.addr, r.status};
endmodule

>>> rtl/htat_checker.sv
// Port-level checker for the host traffic accounting table.
module htat_checker import htat_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RspBits-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[110:104] <= 7'd64)
      else $error("local_used out of range");
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_CLEARED |-> rsp_tdata[110:3] == '0)
      else $error("clear response not zero");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response after reset");
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");
endmodule

bind host_traffic_accounting_table_core htat_checker u_chk (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

>>> tb/testbench.sv
// Self-checking testbench for the host traffic accounting table core.
module testbench;
   import htat_pkg::*;

   localparam int NumLocal  = 64;
   localparam int NumRemote = 16;
   localparam int WdogLimit = 40000;   // cycles with no word moving on either side
   localparam int SettleCyc = 200;     // longer than the worst packet scan
   localparam int HoldCyc   = 1500;    // long receiver hold-off
   localparam int PhaseWords = 200;

   // expected response word, one field per member
   typedef struct {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [4:0]  sess;
      logic [31:0] up;
      logic [31:0] dn;
      logic [6:0]  used;
   } acct_rsp_type;

   // directed stimulus row; want is only used when chk is set
   typedef struct {
      logic [1:0]  mode;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] len;
      logic [5:0]  ls;
      logic [3:0]  rs;
      bit          chk;
      logic [2:0]  st;
      logic [31:0] addr;
      logic [4:0]  sess;
      logic [31:0] up;
      logic [31:0] dn;
      logic [6:0]  used;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqBits-1:0]  req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspBits-1:0]  rsp_tdata;
   logic                csr_we = 1'b0;
   logic [0:0]          csr_index = CSR_PREFIX;
   logic [31:0]         csr_wdata = '0;

   always #4 clock = ~clock;

   host_traffic_accounting_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Shadow copy of the accounting tables
   // ---------------------------------------------------------------------------
   logic [31:0] home_net = HomePrefixRst;
   logic [31:0] home_msk = HomeMaskRst;
   int          n_local = 0;
   logic [31:0] host_addr [NumLocal];
   int          host_sess [NumLocal];
   logic [31:0] host_up   [NumLocal];
   logic [31:0] host_dn   [NumLocal];
   logic [31:0] peer_addr [NumLocal*NumRemote];
   logic [31:0] peer_up   [NumLocal*NumRemote];
   logic [31:0] peer_dn   [NumLocal*NumRemote];

   acct_rsp_type rsp_due_q [$];
   int          mismatches = 0;
   int          idle_cyc = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_go = 1'b0;
   logic        long_hold = 1'b0;
   int          words_in = 0;
   int          words_out = 0;
   int          status_seen [8];

   function automatic logic [31:0] sat32(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [ReqBits-1:0] req_word(input logic [1:0] mode,
         input logic [31:0] src, input logic [31:0] dst, input logic [15:0] len,
         input logic [5:0] ls, input logic [3:0] rs);
      return {4'd0, rs, ls, len, dst, src, mode};
   endfunction

   // Works out the response to one accepted request word and updates the shadow.
   task automatic account(input logic [ReqBits-1:0] w, output acct_rsp_type r);
      logic [1:0]  mode;
      logic [31:0] src, dst, lh, rh, home;
      logic [15:0] len;
      int          ls, rs, i, j, base;
      bit          up, hit;
      mode = w[1:0];
      src  = w[33:2];
      dst  = w[65:34];
      len  = w[81:66];
      ls   = int'(w[87:82]);
      rs   = int'(w[91:88]);
      r.status = ST_EMPTY;
      r.addr = '0; r.sess = '0; r.up = '0; r.dn = '0;
      case (mode)
         MODE_COUNT: begin
            home = home_net & home_msk;
            hit = 1'b1;
            up = 1'b0;
            lh = dst;
            rh = src;
            if ((src & home_msk) == home) begin
               up = 1'b1; lh = src; rh = dst;
            end else if ((dst & home_msk) != home) begin
               hit = 1'b0;
               r.status = ST_NOT_HOME;
            end
            if (hit) begin
               i = 0;
               while (i < n_local && host_addr[i] != lh) i++;
               if (i == n_local && n_local >= NumLocal) begin
                  r.status = ST_LOCAL_FULL;
               end else begin
                  if (i == n_local) begin
                     host_addr[i] = lh; host_sess[i] = 0;
                     host_up[i] = '0; host_dn[i] = '0;
                     n_local++;
                  end
                  if (up) host_up[i] = sat32(host_up[i], len);
                  else    host_dn[i] = sat32(host_dn[i], len);
                  base = i * NumRemote;
                  r.status = up ? ST_UP : ST_DOWN;
                  j = 0;
                  while (j < host_sess[i] && peer_addr[base+j] != rh) j++;
                  if (j == host_sess[i] && j >= NumRemote) begin
                     r.status = ST_REMOTE_FULL;   // local totals still counted
                  end else begin
                     if (j == host_sess[i]) begin
                        peer_addr[base+j] = rh; peer_up[base+j] = '0;
                        peer_dn[base+j] = '0;
                        host_sess[i]++;
                     end
                     if (up) peer_up[base+j] = sat32(peer_up[base+j], len);
                     else    peer_dn[base+j] = sat32(peer_dn[base+j], len);
                  end
                  r.addr = host_addr[i]; r.sess = host_sess[i][4:0];
                  r.up = host_up[i]; r.dn = host_dn[i];
               end
            end
         end
         MODE_RD_LOC: begin
            if (ls < n_local) begin
               r.status = ST_READ_OK; r.addr = host_addr[ls];
               r.sess = host_sess[ls][4:0]; r.up = host_up[ls]; r.dn = host_dn[ls];
            end
         end
         MODE_RD_REM: begin
            if (ls < n_local && rs < host_sess[ls]) begin
               base = ls * NumRemote + rs;
               r.status = ST_READ_OK; r.addr = peer_addr[base];
               r.up = peer_up[base]; r.dn = peer_dn[base];
            end
         end
         default: begin
            n_local = 0;
            r.status = ST_CLEARED;
         end
      endcase
      r.used = n_local[6:0];
   endtask

   // ---------------------------------------------------------------------------
   // Sender side: optional gap, then hold the word until it is taken.
   // want_ok overrides the predicted response with a hand-typed one.
   // ---------------------------------------------------------------------------
   task automatic push_req(input logic [ReqBits-1:0] w, input bit want_ok,
                           input acct_rsp_type want);
      acct_rsp_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      account(w, r);
      rsp_due_q.push_back(want_ok ? want : r);
      words_in++;
   endtask

   task automatic drain_rsp;
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   // Config is only touched with the engine idle: drain, then let any late
   // scan finish before writing.
   task automatic set_home(input logic [31:0] pfx, input logic [31:0] msk);
      req_tvalid <= 1'b0;
      @(posedge clock);
      drain_rsp();
      repeat (SettleCyc) @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_PREFIX; csr_wdata <= pfx;
      @(posedge clock);
      home_net = pfx;
      csr_index <= CSR_MASK; csr_wdata <= msk;
      @(posedge clock);
      home_msk = msk;
      csr_we <= 1'b0;
   endtask

   // Random word: mostly well-formed packets drawn from small host pools so
   // tables fill and lists overflow, plus reads, noise and rare clears.
   task automatic make_word(output logic [ReqBits-1:0] w);
      int          pick, k, rr;
      logic [31:0] lh, rh, src, dst;
      logic [15:0] len;
      logic [5:0]  ls;
      logic [3:0]  rs;
      pick = $urandom_range(999);
      k  = ($urandom_range(3) == 0) ? $urandom_range(79) : $urandom_range(7);
      rr = $urandom_range(23);
      lh = (home_net & home_msk) | ((k * 32'h9E37_79B1 + 32'h2F) & ~home_msk);
      rh = rr * 32'h85EB_CA6B ^ 32'h5A5A_0001;
      case ($urandom_range(3))
         0:       len = 16'hFFFF;
         1:       len = $urandom_range(63);
         default: len = $urandom_range(16'hFFFF);
      endcase
      ls = $urandom_range(63);
      rs = $urandom_range(15);
      if (n_local > 0 && $urandom_range(3) != 0) ls = $urandom_range(n_local - 1);
      if (pick < 360)      w = req_word(MODE_COUNT, lh, rh, len, ls, rs);
      else if (pick < 720) w = req_word(MODE_COUNT, rh, lh, len, ls, rs);
      else if (pick < 800) begin
         src = $urandom; dst = $urandom;
         w = req_word(MODE_COUNT, src, dst, len, ls, rs);
      end
      else if (pick < 895) w = req_word(MODE_RD_LOC, $urandom, $urandom, len, ls, rs);
      else if (pick < 995) w = req_word(MODE_RD_REM, $urandom, $urandom, len, ls, rs);
      else                 w = req_word(MODE_CLEAR, $urandom, $urandom, len, ls, rs);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side
   // ---------------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= !long_hold && ($urandom_range(99) >= stall_pct);

   // long hold-off, counted here; sender keeps offering so the block backs up
   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HoldCyc) @(posedge clock);
      long_hold <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      acct_rsp_type e;
      acct_rsp_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.status = rsp_tdata[2:0];
         a.addr   = rsp_tdata[34:3];
         a.sess   = rsp_tdata[39:35];
         a.up     = rsp_tdata[71:40];
         a.dn     = rsp_tdata[103:72];
         a.used   = rsp_tdata[110:104];
         words_out++;
         status_seen[a.status]++;
         if (rsp_due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response word status=%0d", a.status);
         end else begin
            e = rsp_due_q.pop_front();
            if (a.status !== e.status || a.addr !== e.addr || a.sess !== e.sess ||
                a.up !== e.up || a.dn !== e.dn || a.used !== e.used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: word %0d exp st=%0d addr=%h sess=%0d up=%h dn=%h",
                            " used=%0d / got st=%0d addr=%h sess=%0d up=%h dn=%h used=%0d"},
                           words_out, e.status, e.addr, e.sess, e.up, e.dn, e.used,
                           a.status, a.addr, a.sess, a.up, a.dn, a.used);
            end
         end
      end
   end

   // watchdog: stalls of the whole pipe, not total run time
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cyc <= 0;
      else
         idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WdogLimit) begin
         $display("ERROR: no progress for %0d cycles", WdogLimit);
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   dir_row_type dir_rows [17];
   logic [31:0] ph_pfx  [6] = '{HomePrefixRst, 32'hC0A8_1500, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'h0A00_0000, HomePrefixRst};
   logic [31:0] ph_msk  [6] = '{HomeMaskRst, 32'hFFFF_FF00, 32'h0000_0000,
                                32'hFFFF_FFFF, 32'hFF00_0000, HomeMaskRst};
   int          ph_send [6] = '{0, 55, 0, 11, 55, 0};
   int          ph_stall[6] = '{0, 0, 55, 11, 0, 55};

   initial begin
      logic [ReqBits-1:0] w;
      acct_rsp_type       want;
      // after reset, default home 192.168.0.0/16
      dir_rows = '{
         '{MODE_RD_LOC, 0, 0, 0, 0, 0, 1,
           ST_EMPTY, 0, 0, 0, 0, 0},
         '{MODE_RD_REM, 0, 0, 0, 63, 15, 1,
           ST_EMPTY, 0, 0, 0, 0, 0},
         '{MODE_COUNT, 32'h0A00_0001, 32'h0A00_0002, 16'd5, 0, 0, 1,
           ST_NOT_HOME, 0, 0, 0, 0, 0},
         '{MODE_COUNT, 32'hC0A8_0001, 32'h0808_0808, 16'hFFFF, 0, 0, 1,
           ST_UP, 32'hC0A8_0001, 1, 32'hFFFF, 0, 1},
         '{MODE_COUNT, 32'h0808_0808, 32'hC0A8_0001, 16'd0, 0, 0, 1,
           ST_DOWN, 32'hC0A8_0001, 1, 32'hFFFF, 0, 1},
         '{MODE_COUNT, 32'h0102_0304, 32'hC0A8_0001, 16'd100, 0, 0, 1,
           ST_DOWN, 32'hC0A8_0001, 2, 32'hFFFF, 100, 1},
         '{MODE_RD_LOC, 0, 0, 0, 0, 0, 1,
           ST_READ_OK, 32'hC0A8_0001, 2, 32'hFFFF, 100, 1},
         '{MODE_RD_REM, 0, 0, 0, 0, 0, 1,
           ST_READ_OK, 32'h0808_0808, 0, 32'hFFFF, 0, 1},
         '{MODE_RD_REM, 0, 0, 0, 0, 1, 1,
           ST_READ_OK, 32'h0102_0304, 0, 0, 100, 1},
         '{MODE_RD_REM, 0, 0, 0, 0, 2, 1,
           ST_EMPTY, 0, 0, 0, 0, 1},
         '{MODE_RD_LOC, 0, 0, 0, 1, 0, 1,
           ST_EMPTY, 0, 0, 0, 0, 1},
         '{MODE_COUNT, 32'hC0A8_FFFF, 32'hFFFF_FFFF, 16'd1, 0, 0, 1,
           ST_UP, 32'hC0A8_FFFF, 1, 1, 0, 2},
         '{MODE_COUNT, 32'h0000_0000, 32'h0000_0000, 16'd0, 0, 0, 1,
           ST_NOT_HOME, 0, 0, 0, 0, 2},
         // source misses, destination matches: download for the destination
         '{MODE_COUNT, 32'hFFFF_FFFF, 32'hC0A8_0000, 16'hFFFF, 6'h3F, 4'hF, 1,
           ST_DOWN, 32'hC0A8_0000, 1, 0, 32'hFFFF, 3},
         '{MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F, 4'hF, 1,
           ST_CLEARED, 0, 0, 0, 0, 0},
         '{MODE_RD_LOC, 0, 0, 0, 0, 0, 1,
           ST_EMPTY, 0, 0, 0, 0, 0},
         // both ends home: source wins, counts as upload
         '{MODE_COUNT, 32'hC0A8_0005, 32'hC0A8_0006, 16'd7, 0, 0, 1,
           ST_UP, 32'hC0A8_0005, 1, 7, 0, 1}
      };
      foreach (status_seen[s]) status_seen[s] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[n]) begin
         want.status = dir_rows[n].st;   want.addr = dir_rows[n].addr;
         want.sess   = dir_rows[n].sess; want.up   = dir_rows[n].up;
         want.dn     = dir_rows[n].dn;   want.used = dir_rows[n].used;
         w = req_word(dir_rows[n].mode, dir_rows[n].src, dir_rows[n].dst,
                      dir_rows[n].len, dir_rows[n].ls, dir_rows[n].rs);
         push_req(w, dir_rows[n].chk, want);
      end

      // random phases; each sets the idle pattern, and each after the first moves the home network
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) set_home(ph_pfx[ph], ph_msk[ph]);
         send_idle_pct = ph_send[ph];
         stall_pct     = ph_stall[ph];
         for (int n = 0; n < PhaseWords; n++) begin
            if (ph == 0 && n == 40) hold_go = 1'b1;
            if (ph == 3 && n == PhaseWords / 2) begin
               // sender pauses until every response is back
               req_tvalid <= 1'b0;
               @(posedge clock);
               drain_rsp();
            end
            make_word(w);
            push_req(w, 1'b0, want);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      drain_rsp();
      repeat (SettleCyc) @(posedge clock);
      $display("tb: %0d request words, %0d responses over 6 home settings", words_in,
               words_out);
      $display("tb: up %0d down %0d nothome %0d lfull %0d rfull %0d rd %0d empty %0d clr %0d",
               status_seen[ST_UP], status_seen[ST_DOWN], status_seen[ST_NOT_HOME],
               status_seen[ST_LOCAL_FULL], status_seen[ST_REMOTE_FULL],
               status_seen[ST_READ_OK], status_seen[ST_EMPTY], status_seen[ST_CLEARED]);
      if (mismatches == 0 && rsp_due_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> host_traffic_accounting_table_core.f
rtl/htat_pkg.sv
rtl/htat_front.sv
rtl/htat_queue.sv
rtl/htat_engine.sv
rtl/host_traffic_accounting_table_core.sv
rtl/htat_checker.sv
tb/testbench.sv
